FILE: hw/rtl/nnc_pkg.sv
// ----------------------------------------------------------------------------
// nnc_pkg: shared types and constants
// Widths, sequencer codes and the isqrt response type for the classifier.
// ----------------------------------------------------------------------------
package nnc_pkg;

	localparam int unsigned MaxEntries  = 256;
	localparam int unsigned IdxBits     = 8;
	localparam int unsigned CountBits   = 9;
	localparam int unsigned FeatBits    = 16;
	localparam int unsigned LabelBits   = 8;
	localparam int unsigned DistBits    = 18;
	localparam int unsigned EntryBits   = 4 * FeatBits;
	// sum of two squared 16-bit differences
	localparam int unsigned SqBits      = 2 * FeatBits + 1;
	// root of SqBits value
	localparam int unsigned RootBits    = FeatBits + 1;
	localparam int unsigned IterBits    = 5;
	localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};

	localparam logic FuncLoad  = 1'b0;
	localparam logic FuncQuery = 1'b1;

	// isqrt unit response
	typedef struct packed {
		logic                done;
		logic [RootBits-1:0] root;
	} sqrt_rsp_t;

endpackage

FILE: hw/rtl/nearest_neighbor_classifier_core.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_classifier_core: 1-nearest-neighbor classifier
// Stores labelled four-feature samples and answers queries by a linear scan.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): func=0 writes a table entry at
//   entry_index (no result); func=1 runs a query.
//   Output channel (out_valid/out_stall): one transfer per query with
//   label_out, distance and found.
//   Config channel (cfg_valid/cfg_ready): writes train_count while idle.
//   A query reads entries 0..train_count-1 (train_count capped at 256)
//   one at a time; per entry the shared isqrt unit runs twice (sepal
//   pair, petal pair), with a read state before and a compare state
//   after. After the last entry the result moves into the output
//   register, where out_valid rises, and the next input is taken once
//   it has moved. An empty table answers with found low and no isqrt run.
//   The result moves into an output register; while it waits the block
//   takes and runs one more query, then holds in_stall high with that
//   result until the register is taken.
//   Reset clears train_count and control state; table contents stay
//   undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_neighbor_classifier_core import nnc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic [IdxBits-1:0]   entry_index,
	input  logic [FeatBits-1:0]  sepal_length,
	input  logic [FeatBits-1:0]  sepal_width,
	input  logic [FeatBits-1:0]  petal_length,
	input  logic [FeatBits-1:0]  petal_width,
	input  logic [LabelBits-1:0] label_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [LabelBits-1:0] label_out,
	output logic [DistBits-1:0]  distance,
	output logic                 found,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CountBits-1:0] cfg_data
);

	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StRead  = 3'd1;
	localparam logic [2:0] StSepal = 3'd2;
	localparam logic [2:0] StPetal = 3'd3;
	localparam logic [2:0] StCmp   = 3'd4;
	localparam logic [2:0] StOut   = 3'd5;

	logic [2:0]           state_q;
	logic [CountBits-1:0] count_q, n_q, idx_q;
	logic [EntryBits-1:0] query_q, feat_rd, wfeat;
	logic [LabelBits-1:0] lab_rd, best_lab_q;
	logic [DistBits-1:0]  best_q, dsum_q;
	logic                 have_q;
	logic                 in_xfer, load_we, sq_start;
	logic                 out_take, res_move;
	logic [LabelBits-1:0] out_label_q;
	logic [DistBits-1:0]  out_dist_q;
	logic                 out_found_q;
	logic [IdxBits-1:0]   ram_addr;
	logic [FeatBits-1:0]  a0, a1, b0, b1, d0, d1;
	sqrt_rsp_t            sq_rsp;

	assign in_stall  = (state_q != StIdle);
	assign cfg_ready = (state_q == StIdle);
	assign in_xfer   = in_valid && !in_stall;
	assign load_we   = in_xfer && (func == FuncLoad);
	assign wfeat     = {sepal_length, sepal_width, petal_length, petal_width};
	assign ram_addr  = load_we ? entry_index : idx_q[IdxBits-1:0];
	assign out_take  = out_valid && !out_stall;
	assign res_move  = (state_q == StOut) && (!out_valid || out_take);

	nnc_ram #(.Width(EntryBits), .Depth(MaxEntries)) u_feat_ram (
		.clk(clk), .we(load_we), .addr(ram_addr), .wdata(wfeat), .rdata(feat_rd)
	);
	nnc_ram #(.Width(LabelBits), .Depth(MaxEntries)) u_label_ram (
		.clk(clk), .we(load_we), .addr(ram_addr), .wdata(label_in), .rdata(lab_rd)
	);

	// operand select for the shared root unit
	always_comb begin
		if (state_q == StSepal) begin
			a0 = query_q[4*FeatBits-1 -: FeatBits];
			a1 = query_q[3*FeatBits-1 -: FeatBits];
			b0 = feat_rd[4*FeatBits-1 -: FeatBits];
			b1 = feat_rd[3*FeatBits-1 -: FeatBits];
		end else begin
			a0 = query_q[2*FeatBits-1 -: FeatBits];
			a1 = query_q[FeatBits-1:0];
			b0 = feat_rd[2*FeatBits-1 -: FeatBits];
			b1 = feat_rd[FeatBits-1:0];
		end
		d0 = (a0 > b0) ? a0 - b0 : b0 - a0;
		d1 = (a1 > b1) ? a1 - b1 : b1 - a1;
	end

	nnc_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .d0(d0), .d1(d1), .start(sq_start), .rsp(sq_rsp)
	);

	logic sq_busy_q;
	assign sq_start = ((state_q == StSepal) || (state_q == StPetal)) && !sq_busy_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StIdle;
			count_q   <= '0;
			out_valid <= 1'b0;
			sq_busy_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (sq_start) sq_busy_q <= 1'b1;
			else if (sq_rsp.done) sq_busy_q <= 1'b0;
			// output register fills on a move, empties on a transfer
			if (res_move) out_valid <= 1'b1;
			else if (out_take) out_valid <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (in_xfer && func == FuncQuery) begin
						state_q <= StRead;
					end
				end
				StRead: begin
					if (idx_q >= n_q) begin
						state_q <= StOut;
					end else begin
						state_q <= StSepal;
					end
				end
				StSepal: if (sq_rsp.done) state_q <= StPetal;
				StPetal: if (sq_rsp.done) state_q <= StCmp;
				StCmp:   state_q <= StRead;
				StOut:   if (res_move) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			StIdle: begin
				query_q    <= wfeat;
				idx_q      <= '0;
				have_q     <= 1'b0;
				best_q     <= DistMax;
				best_lab_q <= '0;
				n_q        <= (count_q > CountBits'(MaxEntries)) ?
					CountBits'(MaxEntries) : count_q;
			end
			StSepal: if (sq_rsp.done) dsum_q <= DistBits'(sq_rsp.root);
			StPetal: if (sq_rsp.done) dsum_q <= dsum_q + DistBits'(sq_rsp.root);
			StCmp: begin
				idx_q <= idx_q + 1'b1;
				if (!have_q || dsum_q < best_q) begin
					have_q     <= 1'b1;
					best_q     <= dsum_q;
					best_lab_q <= lab_rd;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (res_move) begin
			out_label_q <= best_lab_q;
			out_dist_q  <= best_q;
			out_found_q <= have_q;
		end
	end

	assign label_out = out_label_q;
	assign distance  = out_dist_q;
	assign found     = out_found_q;

endmodule

FILE: hw/rtl/nnc_ram.sv
// ----------------------------------------------------------------------------
// nnc_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module nnc_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: hw/rtl/nnc_isqrt.sv
// ----------------------------------------------------------------------------
// nnc_isqrt: iterative integer square root
// Sums two squared differences, then does one root bit per cycle.
// ----------------------------------------------------------------------------
module nnc_isqrt import nnc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [FeatBits-1:0] d0,
	input  logic [FeatBits-1:0] d1,
	input  logic                start,
	output sqrt_rsp_t           rsp
);

	localparam int unsigned Steps = (SqBits + 1) / 2;
	localparam int unsigned RemBits = SqBits + 1;

	logic [2*FeatBits-1:0] sq0_q, sq1_q;
	// radicand padded to an even width
	logic [RemBits-1:0]    rad_q;
	logic [RemBits-1:0]    rem_q;
	logic [RootBits-1:0]   root_q;
	logic [IterBits-1:0]   step_q;
	logic [1:0]            phase_q;
	logic                  done_q;
	logic [RemBits-1:0]    rem_sh, trial;

	localparam logic [1:0] PhIdle = 2'd0;
	localparam logic [1:0] PhSq   = 2'd1;
	localparam logic [1:0] PhSum  = 2'd2;
	localparam logic [1:0] PhRoot = 2'd3;

	// shift two radicand bits into remainder, trial subtract
	always_comb begin
		rem_sh = {rem_q[RemBits-3:0], rad_q[RemBits-1 -: 2]};
		trial  = RemBits'({root_q, 2'b01});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhIdle;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PhIdle: if (start) phase_q <= PhSq;
				PhSq:   phase_q <= PhSum;
				PhSum:  phase_q <= PhRoot;
				PhRoot: begin
					if (step_q == IterBits'(Steps - 1)) begin
						phase_q <= PhIdle;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= PhIdle;
			endcase
		end
	end

	// datapath: squares, sum, then restoring root iterations
	always_ff @(posedge clk) begin
		unique case (phase_q)
			PhIdle: begin
				sq0_q <= (2*FeatBits)'(d0) * (2*FeatBits)'(d0);
				sq1_q <= (2*FeatBits)'(d1) * (2*FeatBits)'(d1);
			end
			PhSq: begin
				rad_q <= RemBits'(sq0_q) + RemBits'(sq1_q);
			end
			PhSum: begin
				rem_q  <= '0;
				root_q <= '0;
				step_q <= '0;
			end
			PhRoot: begin
				rad_q  <= {rad_q[RemBits-3:0], 2'b00};
				step_q <= step_q + 1'b1;
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[RootBits-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[RootBits-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule
